// ===== hdl/gbp_pkg.sv =====
// ----------------------------------------------------------------------------
// gbp_pkg
// Shared constants, register indexes and counter helpers for the gshare
// branch predictor.
// ----------------------------------------------------------------------------
package gbp_pkg;

   localparam int MAX_INDEX_BITS_DEF = 14;

   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int TOTAL_W   = 32;
   localparam int ADDR_W    = 32;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INDEX_BITS   = 2'd0,
      CSR_HISTORY_BITS = 2'd1
   } csr_index_type;

   localparam logic [CFG_W-1:0] INDEX_BITS_RESET   = 4'd14;
   localparam logic [CFG_W-1:0] HISTORY_BITS_RESET = 4'd8;

   typedef logic [1:0] ctr_type;

   localparam ctr_type CTR_RESET = 2'd2;
   localparam ctr_type CTR_MAX   = 2'd3;
   localparam ctr_type CTR_MIN   = 2'd0;

   function automatic ctr_type ctr_update(input ctr_type ctr, input logic taken);
      ctr_type result;
      result = ctr;
      if (taken) begin
         if (ctr != CTR_MAX) begin
            result = ctr + 2'd1;
         end
      end else begin
         if (ctr != CTR_MIN) begin
            result = ctr - 2'd1;
         end
      end
      return result;
   endfunction

endpackage

// ===== hdl/gbp_table.sv =====
// ----------------------------------------------------------------------------
// gbp_table
// Pattern history table: one synchronous memory of 2-bit counters with a
// registered read port, one write port and a clearing pass after reset.
// ----------------------------------------------------------------------------
module gbp_table #(
   parameter int IDX_W = gbp_pkg::MAX_INDEX_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output gbp_pkg::ctr_type   rd_data,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  gbp_pkg::ctr_type   wr_data,
   output logic               clear_busy
);

   localparam int DEPTH = 1 << IDX_W;

   gbp_pkg::ctr_type mem [DEPTH];

   gbp_pkg::ctr_type   rd_data_ff;
   logic               clear_busy_ff;
   logic               clear_busy_in;
   logic [IDX_W-1:0]   clr_addr_ff;
   logic [IDX_W-1:0]   clr_addr_in;

   always_comb begin
      clr_addr_in   = clr_addr_ff;
      clear_busy_in = clear_busy_ff;
      if (clear_busy_ff) begin
         clr_addr_in = clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == {IDX_W{1'b1}}) begin
            clear_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         clear_busy_ff <= clear_busy_in;
         clr_addr_ff   <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         mem[clr_addr_ff] <= gbp_pkg::CTR_RESET;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clear_busy_ff;

endmodule

// ===== hdl/gshare_branch_predictor.sv =====
// ----------------------------------------------------------------------------
// gshare_branch_predictor
// Predicts and trains on resolved branches with a gshare-indexed table of
// 2-bit saturating counters and counts predictions and mispredictions.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one beat per resolved branch (address, actual direction),
//   taken when req_valid is high and req_stall low.
//   rsp_ channel: one beat per request with the prediction made before the
//   update, the mispredict flag and the running totals, in request order.
//   csr_ port: write index_bits (index 0) or history_bits (index 1) while
//   the block is idle; other indexes are ignored.
// Path: a request is registered in the table stage, then in the rsp_ registers.
// Throughput: one branch per cycle while rsp_ is not stalled. The table
//   read is issued on acceptance, the counter is written back as the entry
//   leaves the table stage; a same-entry update is forwarded to the next request.
// Reset: synchronous. Afterwards all 2^MAX_INDEX_BITS table entries (16384
//   by default) are swept to weakly taken, one entry per cycle; req_stall
//   stays high during the sweep. History, totals and registers reset at once.
// Stall: while rsp_stall holds a result, one more request can enter and park
//   in the table stage; after that req_stall is raised until the result leaves.
// ----------------------------------------------------------------------------
module gshare_branch_predictor #(
   parameter int MAX_INDEX_BITS = gbp_pkg::MAX_INDEX_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [gbp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [gbp_pkg::CFG_W-1:0]        csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [gbp_pkg::ADDR_W-1:0]       req_branch_address,
   input  logic                             req_actual_taken,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_predicted_taken,
   output logic                             rsp_mispredicted,
   output logic [gbp_pkg::TOTAL_W-1:0]      rsp_prediction_total,
   output logic [gbp_pkg::TOTAL_W-1:0]      rsp_miss_total
);

   localparam int IDX_W  = MAX_INDEX_BITS;
   localparam int CLOG_W = $clog2(MAX_INDEX_BITS + 1);
   localparam int M_W    = (CLOG_W > gbp_pkg::CFG_W) ? CLOG_W : gbp_pkg::CFG_W;

   function automatic logic [IDX_W-1:0] low_mask(input logic [M_W-1:0] bits);
      logic [IDX_W:0] bit_one;
      bit_one = (IDX_W + 1)'(1) << bits;
      return IDX_W'(bit_one - (IDX_W + 1)'(1));
   endfunction

   logic [gbp_pkg::CFG_W-1:0]    index_bits_ff;
   logic [gbp_pkg::CFG_W-1:0]    index_bits_in;
   logic [gbp_pkg::CFG_W-1:0]    history_bits_ff;
   logic [gbp_pkg::CFG_W-1:0]    history_bits_in;
   logic [IDX_W-1:0]             hist_ff;
   logic [IDX_W-1:0]             hist_in;

   logic                         s1_valid_ff;
   logic                         s1_valid_in;
   logic [IDX_W-1:0]             s1_idx_ff;
   logic                         s1_taken_ff;
   logic                         fwd_ff;
   logic                         fwd_in;
   gbp_pkg::ctr_type             fwd_ctr_ff;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic                         rsp_pred_ff;
   logic                         rsp_miss_ff;
   logic [gbp_pkg::TOTAL_W-1:0]  pred_cnt_ff;
   logic [gbp_pkg::TOTAL_W-1:0]  pred_cnt_in;
   logic [gbp_pkg::TOTAL_W-1:0]  miss_cnt_ff;
   logic [gbp_pkg::TOTAL_W-1:0]  miss_cnt_in;

   logic [M_W-1:0]               ib_ext;
   logic [M_W-1:0]               hb_ext;
   logic [M_W-1:0]               m_eff;
   logic [M_W-1:0]               n_eff;
   logic [IDX_W-1:0]             m_mask;
   logic [IDX_W-1:0]             n_mask;
   logic [IDX_W-1:0]             hist_masked;
   logic [IDX_W-1:0]             addr_field;
   logic [IDX_W-1:0]             req_idx;
   logic [IDX_W-1:0]             hist_shifted;

   logic                         accept;
   logic                         s1_advance;
   logic                         clear_busy;
   gbp_pkg::ctr_type             rd_data;
   gbp_pkg::ctr_type             ctr_cur;
   gbp_pkg::ctr_type             ctr_new;
   logic                         pred;
   logic                         miss;

   // effective index and history lengths
   always_comb begin
      ib_ext = M_W'(index_bits_ff);
      hb_ext = M_W'(history_bits_ff);
      if (ib_ext == '0) begin
         m_eff = M_W'(1);
      end else if (ib_ext > M_W'(MAX_INDEX_BITS)) begin
         m_eff = M_W'(MAX_INDEX_BITS);
      end else begin
         m_eff = ib_ext;
      end
      n_eff = (hb_ext > m_eff) ? m_eff : hb_ext;
   end

   assign m_mask      = low_mask(m_eff);
   assign n_mask      = low_mask(n_eff);
   assign hist_masked = hist_ff & n_mask;
   assign addr_field  = req_branch_address[IDX_W+1:2];
   assign req_idx     = (addr_field ^ (hist_masked << (m_eff - n_eff))) & m_mask;

   always_comb begin
      hist_shifted = (hist_masked >> 1)
                   | (IDX_W'(req_actual_taken) << (n_eff - M_W'(1)));
      hist_in      = hist_ff;
      if (accept && (n_eff != '0)) begin
         hist_in = hist_shifted & n_mask;
      end
   end

   // handshake
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clear_busy || (s1_valid_ff && !s1_advance);
   assign accept     = req_valid && !req_stall;

   // table stage
   assign ctr_cur = fwd_ff ? fwd_ctr_ff : rd_data;
   assign pred    = ctr_cur[1];
   assign miss    = pred ^ s1_taken_ff;
   assign ctr_new = gbp_pkg::ctr_update(ctr_cur, s1_taken_ff);

   gbp_table #(
      .IDX_W (IDX_W)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (req_idx),
      .rd_data    (rd_data),
      .wr_en      (s1_advance),
      .wr_addr    (s1_idx_ff),
      .wr_data    (ctr_new),
      .clear_busy (clear_busy)
   );

   always_comb begin
      index_bits_in   = index_bits_ff;
      history_bits_in = history_bits_ff;
      if (csr_we) begin
         case (csr_index)
            gbp_pkg::CSR_INDEX_BITS:   index_bits_in   = csr_wdata;
            gbp_pkg::CSR_HISTORY_BITS: history_bits_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end
      fwd_in = s1_advance && (s1_idx_ff == req_idx);

      rsp_valid_in = rsp_valid_ff;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      pred_cnt_in = pred_cnt_ff;
      miss_cnt_in = miss_cnt_ff;
      if (s1_advance) begin
         pred_cnt_in = pred_cnt_ff + gbp_pkg::TOTAL_W'(1);
         miss_cnt_in = miss_cnt_ff + gbp_pkg::TOTAL_W'(miss);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_bits_ff   <= gbp_pkg::INDEX_BITS_RESET;
         history_bits_ff <= gbp_pkg::HISTORY_BITS_RESET;
         hist_ff         <= '0;
         s1_valid_ff     <= 1'b0;
         fwd_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         pred_cnt_ff     <= '0;
         miss_cnt_ff     <= '0;
      end else begin
         index_bits_ff   <= index_bits_in;
         history_bits_ff <= history_bits_in;
         hist_ff         <= hist_in;
         s1_valid_ff     <= s1_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         pred_cnt_ff     <= pred_cnt_in;
         miss_cnt_ff     <= miss_cnt_in;
         if (accept) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_idx_ff   <= req_idx;
         s1_taken_ff <= req_actual_taken;
         fwd_ctr_ff  <= ctr_new;
      end
      if (s1_advance) begin
         rsp_pred_ff <= pred;
         rsp_miss_ff <= miss;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_predicted_taken  = rsp_pred_ff;
   assign rsp_mispredicted     = rsp_miss_ff;
   assign rsp_prediction_total = pred_cnt_ff;
   assign rsp_miss_total       = miss_cnt_ff;

`ifndef NO_ASSERTIONS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !accept)
      else $error("request taken during table clear");

   a_s1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_idx_ff)))
      else $error("parked table stage lost its entry");

   a_fwd_needs_s1: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> (s1_valid_ff || !$past(accept)))
      else $error("forward flag set without a table-stage beat");

   a_total_steps: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (pred_cnt_ff == $past(pred_cnt_ff) + gbp_pkg::TOTAL_W'(1)))
      else $error("prediction total did not advance by one");

   a_miss_flag: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> (rsp_valid_ff && (rsp_miss_ff == (rsp_pred_ff ^ $past(s1_taken_ff)))))
      else $error("mispredict flag disagrees with direction");
`endif

endmodule
